@@ rtl/sound_cpu_bus_map_with_bank_window_macros.svh @@
`ifndef SOUND_CPU_BUS_MAP_WITH_BANK_WINDOW_MACROS_SVH
`define SOUND_CPU_BUS_MAP_WITH_BANK_WINDOW_MACROS_SVH

// check prop on every edge outside reset
`define SBW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every edge, reset included
`define SBW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sbw_pkg.sv @@
`timescale 1ns / 1ps

package sbw_pkg;

    localparam int RAM_BYTES_DEF = 8192;

    localparam logic [2:0] OP_CPU_READ    = 3'd0;
    localparam logic [2:0] OP_CPU_WRITE   = 3'd1;
    localparam logic [2:0] OP_BUSREQ_READ = 3'd2;
    localparam logic [2:0] OP_BUSREQ_WR   = 3'd3;
    localparam logic [2:0] OP_RESET_WR    = 3'd4;

    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_RAM  = 3'd1;
    localparam logic [2:0] TGT_FM   = 3'd2;
    localparam logic [2:0] TGT_PSG  = 3'd3;
    localparam logic [2:0] TGT_HOST = 3'd4;

    localparam logic [15:0] RAM_END   = 16'h2000;
    localparam logic [15:0] HOST_BASE = 16'h8000;
    localparam logic [15:0] FM_FIRST  = 16'h4000;
    localparam logic [15:0] FM_LAST   = 16'h4003;
    localparam logic [15:0] BANK_ADDR = 16'h6000;
    localparam logic [15:0] PSG_ADDR  = 16'h7F11;

    localparam logic [3:0] BANK_WRITES = 4'd9;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] cpu_address;
        logic [7:0]  write_value;
        logic [7:0]  fm_status;
    } in_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [1:0]  fm_port;
        logic [23:0] host_address;
        logic [7:0]  out_write_data;
        logic        is_write;
        logic [7:0]  read_data;
        logic        read_pending;
        logic        cpu_reset_pulse;
        logic        cpu_held;
    } out_t;

    typedef struct packed {
        logic       re;
        logic       we;
        logic [7:0] wdata;
    } ram_req_t;

endpackage

@@ rtl/sound_cpu_bus_map_with_bank_window.sv @@
`timescale 1ns / 1ps

// Bus decoder for an 8-bit sound CPU with local RAM and a banked host window.
// Input channel (in_valid/in_ready/in_data) carries one transaction: a CPU
// read or write, a bus-request read or write, or a reset line write.
// Output channel (out_valid/out_ready/out_data) returns one decoded result per
// transaction, in order.
// out_valid rises the cycle after acceptance. Throughput: one transaction per
// cycle unless stalled; the local RAM is a single-port synchronous memory
// touched once per transaction; its registered read data joins the result
// register. Reset: control state clears, bus request and reset line come up
// asserted, then the RAM is swept to zero, one byte a cycle, over all
// RAM_BYTES bytes (8192 by default); in_ready stays low during the sweep.
// Stall: while out_ready is low the result holds and in_ready drops once the
// result register is full; a transaction may be taken in the cycle the
// result is taken.
module sound_cpu_bus_map_with_bank_window
    import sbw_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int AW = $clog2(RAM_BYTES);

    ram_req_t      ram_req;
    logic [AW-1:0] ram_idx;
    logic [7:0]    ram_rdata;
    logic          ram_busy;
    out_t          result;
    logic          accept;

    logic          valid_reg;
    out_t          res_reg;
    logic          ram_sel_reg;

    assign in_ready = !ram_busy && (!valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    sbw_decode #(
        .RAM_BYTES (RAM_BYTES),
        .AW        (AW)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .ram_req (ram_req),
        .ram_idx (ram_idx),
        .result  (result)
    );

    sbw_ram #(
        .RAM_BYTES (RAM_BYTES),
        .AW        (AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .idx   (ram_idx),
        .rdata (ram_rdata),
        .busy  (ram_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg     <= result;
            ram_sel_reg <= ram_req.re;
        end
    end

    always_comb
    begin
        out_data = res_reg;
        if (ram_sel_reg)
        begin
            out_data.read_data = ram_rdata;
        end
    end

    assign out_valid = valid_reg;

endmodule

@@ rtl/sbw_ram.sv @@
`timescale 1ns / 1ps

module sbw_ram
    import sbw_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF,
    parameter int AW        = $clog2(RAM_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ram_req_t      req,
    input  logic [AW-1:0] idx,
    output logic [7:0]    rdata,
    output logic          busy
);

    localparam logic [AW-1:0] LAST_IDX = AW'(RAM_BYTES - 1);

    logic [7:0]    mem [RAM_BYTES];
    logic [7:0]    rdata_reg;
    logic          clear_reg;
    logic [AW-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clr_idx_reg] <= 8'h00;
        end
        else if (req.we)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clear_reg;

endmodule

@@ rtl/sbw_decode.sv @@
`timescale 1ns / 1ps

module sbw_decode
    import sbw_pkg::*;
#(
    parameter int RAM_BYTES = RAM_BYTES_DEF,
    parameter int AW        = $clog2(RAM_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  in_t           in_data,
    output ram_req_t      ram_req,
    output logic [AW-1:0] ram_idx,
    output out_t          result
);

    localparam logic [15:0] SPAN1 = 16'(RAM_BYTES);
    localparam logic [15:0] SPAN2 = 16'(2 * RAM_BYTES);
    localparam logic [15:0] SPAN4 = 16'(4 * RAM_BYTES);

    logic [8:0] bank_bits_reg, bank_bits_next;
    logic [8:0] bank_shift_reg, bank_shift_next;
    logic [3:0] bank_count_reg, bank_count_next;
    logic       bus_req_reg, bus_req_next;
    logic       reset_line_reg, reset_line_next;

    logic        wr;
    logic [15:0] addr;
    logic [15:0] r0, r1, r2, r3;
    logic [3:0]  count_inc;

    always_comb
    begin
        r0 = {3'b000, in_data.cpu_address[12:0]};
        r1 = (r0 >= SPAN4) ? r0 - SPAN4 : r0;
        r2 = (r1 >= SPAN2) ? r1 - SPAN2 : r1;
        r3 = (r2 >= SPAN1) ? r2 - SPAN1 : r2;
        ram_idx = r3[AW-1:0];
    end

    always_comb
    begin
        addr            = in_data.cpu_address;
        wr              = (in_data.operation == OP_CPU_WRITE);
        count_inc       = bank_count_reg + 4'd1;
        bank_bits_next  = bank_bits_reg;
        bank_shift_next = bank_shift_reg;
        bank_count_next = bank_count_reg;
        bus_req_next    = bus_req_reg;
        reset_line_next = reset_line_reg;
        ram_req         = '0;
        result          = '0;

        case (in_data.operation)
            OP_CPU_READ, OP_CPU_WRITE:
            begin
                if (addr < RAM_END)
                begin
                    result.target = TGT_RAM;
                    if (wr)
                    begin
                        ram_req.we            = accept;
                        ram_req.wdata         = in_data.write_value;
                        result.out_write_data = in_data.write_value;
                        result.is_write       = 1'b1;
                    end
                    else
                    begin
                        ram_req.re = accept;
                    end
                end
                else if (addr >= HOST_BASE)
                begin
                    result.target       = TGT_HOST;
                    result.host_address = {bank_bits_reg, addr[14:0]};
                    if (wr)
                    begin
                        result.out_write_data = in_data.write_value;
                        result.is_write       = 1'b1;
                    end
                    else
                    begin
                        result.read_pending = 1'b1;
                    end
                end
                else if (addr inside {[FM_FIRST:FM_LAST]})
                begin
                    result.target  = TGT_FM;
                    result.fm_port = addr[1:0];
                    if (wr)
                    begin
                        result.out_write_data = in_data.write_value;
                        result.is_write       = 1'b1;
                    end
                    else
                    begin
                        result.read_data = in_data.fm_status;
                    end
                end
                else if (wr && addr == BANK_ADDR)
                begin
                    bank_shift_next = {in_data.write_value[0], bank_shift_reg[8:1]};
                    if (count_inc >= BANK_WRITES)
                    begin
                        bank_count_next = '0;
                        bank_bits_next  = bank_shift_next;
                    end
                    else
                    begin
                        bank_count_next = count_inc;
                    end
                end
                else if (wr && addr == PSG_ADDR)
                begin
                    result.target         = TGT_PSG;
                    result.out_write_data = in_data.write_value;
                    result.is_write       = 1'b1;
                end
            end
            OP_BUSREQ_READ:
            begin
                result.read_data = {7'd0, ~bus_req_reg};
            end
            OP_BUSREQ_WR:
            begin
                bus_req_next = in_data.write_value[0];
            end
            OP_RESET_WR:
            begin
                result.cpu_reset_pulse = reset_line_reg & ~in_data.write_value[0];
                reset_line_next        = in_data.write_value[0];
            end
            default:
            begin
            end
        endcase

        result.cpu_held = bus_req_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_bits_reg  <= '0;
            bank_shift_reg <= '0;
            bank_count_reg <= '0;
            bus_req_reg    <= 1'b1;
            reset_line_reg <= 1'b1;
        end
        else if (accept)
        begin
            bank_bits_reg  <= bank_bits_next;
            bank_shift_reg <= bank_shift_next;
            bank_count_reg <= bank_count_next;
            bus_req_reg    <= bus_req_next;
            reset_line_reg <= reset_line_next;
        end
    end

endmodule

@@ rtl/sbw_checker.sv @@
`timescale 1ns / 1ps

`include "sound_cpu_bus_map_with_bank_window_macros.svh"

module sbw_checker
    import sbw_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    logic stalled;
    logic in_wait;
    logic pending_ok;
    logic write_ok;

    assign stalled    = out_valid && !out_ready;
    assign in_wait    = in_valid && !in_ready;
    assign pending_ok = !out_data.read_pending
                        || (out_data.target == TGT_HOST && !out_data.is_write);
    assign write_ok   = !out_data.is_write
                        || (out_data.read_data == 8'h00 && !out_data.read_pending);

    `SBW_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "stalled result moved")
    `SBW_ASSERT(a_in_hold, in_wait |=> in_valid && $stable(in_data), "waiting transaction moved")
    `SBW_ASSERT(a_pending_host, out_valid |-> pending_ok, "read pending outside a host read")
    `SBW_ASSERT(a_write_no_read, out_valid |-> write_ok, "write carries read data")
    `SBW_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result shown during reset")

endmodule

bind sound_cpu_bus_map_with_bank_window sbw_checker u_sbw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
